FILE: sv/kqs_pkg.sv
// shared constants for the k-queues shared store: pool geometry, pointer widths,
// operation and status codes
// no dependencies
package kqs_pkg;

    // pool and queue geometry
    localparam int SLOTS   = 16;
    localparam int QUEUES  = 4;

    // a pointer holds a slot number or the null code SLOTS
    localparam int PTR_W   = $clog2(SLOTS + 1);
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int QID_W   = 2;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOTS);

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

endpackage

FILE: sv/kqs_if.sv
// valid/ready channel interfaces for the k-queues shared store
// depends on kqs_pkg
interface kqs_in_if import kqs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [QID_W-1:0]         queue_id;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output op, output queue_id, output value, input ready);
    modport sink   (input valid, input op, input queue_id, input value, output ready);
endinterface

interface kqs_out_if import kqs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data_out;

    modport source (output valid, output status, output data_out, input ready);
    modport sink   (input valid, input status, input data_out, output ready);
endinterface

FILE: sv/k_queues_shared_store.sv
// Several FIFO queues sharing one pool of slots kept in two synchronous memories (slot data
// and next-slot link), free slots chained on a free list. Each word is handled in order: the
// accept cycle reads the slot memories at the free head (push) or the queue head (pop), then
// the update stage uses the registered read data to relink pointers and loads the result register.
// A new word is taken whenever the update stage is empty, even while a result waits in the
// output register; the update stage holds while that register is still full. Link entries
// carry per-slot valid bits cleared at reset, so the block is usable from the first cycle
// with no clearing pass. Refused pushes (pool full) and pops (queue empty) return a status
// code and zero data.
module k_queues_shared_store import kqs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kqs_in_if.sink     i_in,
    kqs_out_if.source  o_out
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // slot memories
    logic [DATA_W-1:0] r_slot_data [SLOTS];
    logic [PTR_W-1:0]  r_slot_link [SLOTS];
    logic [SLOTS-1:0]  r_link_vld;

    // pointer registers
    logic [PTR_W-1:0]  r_queue_head [QUEUES];
    logic [PTR_W-1:0]  r_queue_tail [QUEUES];
    logic [PTR_W-1:0]  r_free_head;

    // word in flight
    logic              r_state;
    logic              r_op;
    logic [QID_W-1:0]  r_q;
    logic [PTR_W-1:0]  r_slot;
    logic              r_ok;
    logic [DATA_W-1:0] r_data_q;
    logic [PTR_W-1:0]  r_link_q;
    logic              r_link_q_vld;

    // result register
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [DATA_W-1:0] r_data_out;

    logic              acc;
    logic [QID_W-1:0]  acc_q;
    logic [PTR_W-1:0]  acc_slot;
    logic              acc_ok;
    logic              adv;
    logic [PTR_W-1:0]  link_rd;
    logic [PTR_W-1:0]  link_next;
    logic              q_live;
    logic              lw_en;
    logic [IDX_W-1:0]  lw_addr;
    logic [PTR_W-1:0]  lw_data;
    logic              dw_en;

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_status;
    assign o_out.data_out = r_data_out;

    // accept side: pick the slot the word works on
    always_comb begin
        acc      = i_in.valid && i_in.ready;
        acc_q    = i_in.queue_id;
        acc_slot = (i_in.op == OP_PUSH) ? r_free_head : r_queue_head[acc_q];
        acc_ok   = (acc_slot < NULL_PTR);
    end

    // update side: registered link, with the reset chain for unwritten entries
    always_comb begin
        adv       = (r_state == S_EXEC) && (!r_out_valid || o_out.ready);
        link_rd   = r_link_q_vld ? r_link_q
                                 : PTR_W'(r_slot[IDX_W-1:0]) + PTR_W'(1);
        link_next = (link_rd < NULL_PTR) ? link_rd : NULL_PTR;
        q_live    = (r_queue_head[r_q] < NULL_PTR) && (r_queue_tail[r_q] < NULL_PTR);
    end

    // single link write port: null at a claimed slot, or a relink during update
    always_comb begin
        lw_en   = 1'b0;
        lw_addr = acc_slot[IDX_W-1:0];
        lw_data = NULL_PTR;
        dw_en   = acc && acc_ok && (i_in.op == OP_PUSH);
        if (adv && r_ok) begin
            if (r_op == OP_PUSH) begin
                lw_en   = q_live;
                lw_addr = r_queue_tail[r_q][IDX_W-1:0];
                lw_data = r_slot;
            end else begin
                lw_en   = 1'b1;
                lw_addr = r_slot[IDX_W-1:0];
                lw_data = r_free_head;
            end
        end else if (dw_en) begin
            lw_en = 1'b1;
        end
    end

    // slot memories, read-first
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_link_q <= r_slot_link[acc_slot[IDX_W-1:0]];
            r_data_q <= r_slot_data[acc_slot[IDX_W-1:0]];
        end
        if (lw_en) begin
            r_slot_link[lw_addr] <= lw_data;
        end
        if (dw_en) begin
            r_slot_data[acc_slot[IDX_W-1:0]] <= i_in.value;
        end
    end

    // link valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld   <= '0;
            r_link_q_vld <= 1'b0;
        end else begin
            if (acc) begin
                r_link_q_vld <= r_link_vld[acc_slot[IDX_W-1:0]];
            end
            if (lw_en) begin
                r_link_vld[lw_addr] <= 1'b1;
            end
        end
    end

    // word in flight
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op   <= i_in.op;
            r_q    <= acc_q;
            r_slot <= acc_slot;
            r_ok   <= acc_ok;
        end
    end

    // control, pointers and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < QUEUES; i++) begin
                r_queue_head[i] <= NULL_PTR;
                r_queue_tail[i] <= NULL_PTR;
            end
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (acc) begin
                r_state <= S_EXEC;
            end
            if (adv) begin
                r_state <= S_IDLE;
                if (!r_ok) begin
                    r_status   <= (r_op == OP_PUSH) ? ST_FULL : ST_EMPTY;
                    r_data_out <= '0;
                end else if (r_op == OP_PUSH) begin
                    r_status          <= ST_OK;
                    r_data_out        <= '0;
                    r_free_head       <= link_next;
                    r_queue_tail[r_q] <= r_slot;
                    if (!q_live) begin
                        r_queue_head[r_q] <= r_slot;
                    end
                end else begin
                    r_status          <= ST_OK;
                    r_queue_head[r_q] <= link_next;
                    r_free_head       <= r_slot;
                    r_data_out        <= r_data_q;
                end
            end
        end
    end

    // a refused push means the free list was empty
    a_full_only_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_op == OP_PUSH && !r_ok) |-> (r_free_head == NULL_PTR))
        else $error("push refused with free slots left");

    // a successful pop puts its slot at the front of the free list
    a_pop_frees_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_op == OP_POP && r_ok) |=> (r_free_head == $past(r_slot)))
        else $error("popped slot not returned to free list");

    // every finished update shows a result next cycle
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_out.valid)
        else $error("update finished without a result");

    // a word only enters the update stage through an accept
    a_exec_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_state) && $past(i_rst_n)) |-> $past(acc))
        else $error("update stage entered without an accepted word");

endmodule
